>>> design/scpu_pkg.sv
// Shared widths, constants and types of the sine/cosine polynomial unit.
`timescale 1ns / 1ps

package scpu_pkg;

  // Fixed-point formats
  localparam int ANGLE_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 16;
  localparam int ANGLE_W          = 32;
  localparam int RESULT_W         = RESULT_FRAC_BITS + 2;
  localparam int Q_FRAC           = 30;

  // Internal Q.30 widths, sized to the value ranges
  localparam int X_W   = Q_FRAC + 1;  // x in [-1, 1)
  localparam int X2_W  = Q_FRAC + 2;  // x*x in [0, 1]
  localparam int R1_W  = Q_FRAC + 2;  // (x-1)(x+1) in [-1, 0]
  localparam int P_W   = Q_FRAC + 4;  // Horner value, |p| < 8
  localparam int ACC_W = Q_FRAC + 4;  // products after the Horner chain

  // 1/pi as round(2^32/pi), positive, held signed
  localparam int INV_PI_W = 32;
  localparam logic signed [INV_PI_W-1:0] INV_PI_Q32 = 32'sd1367130551;

  // Phase field position in angle * (1/pi)
  localparam int PHASE_LSB = ANGLE_FRAC_BITS + 2;

  localparam logic [X_W-1:0] ONE_Q30       = X_W'(64'd1 << Q_FRAC);
  localparam logic [X_W-1:0] SINE_OFFSET   = X_W'(64'd1 << Q_FRAC);
  localparam logic [X_W-1:0] COSINE_OFFSET = X_W'(64'd3 << (Q_FRAC - 1));
  localparam int             HALF_Q30      = 1 << (Q_FRAC - 1);

  // Output rounding and saturation
  localparam int OUT_SHIFT = Q_FRAC - RESULT_FRAC_BITS;
  localparam int OUT_HALF  = (1 << OUT_SHIFT) >> 1;

  // Horner coefficients, round(c * 2^30), highest power first
  localparam int NUM_COEF     = 6;
  localparam int HORNER_STEPS = NUM_COEF - 1;
  localparam logic signed [P_W-1:0] COEF_Q30 [NUM_COEF] = '{
    34'sd414398,
    -34'sd7366070,
    34'sd80731709,
    -34'sd562679533,
    34'sd2175529209,
    -34'sd3373259416
  };

  typedef enum logic {
    CMD_SINE   = 1'b0,
    CMD_COSINE = 1'b1
  } cmd_e;

  // Horner stage to output stage
  typedef struct packed {
    logic signed [X_W-1:0]  x;
    logic signed [R1_W-1:0] r1;
    logic signed [P_W-1:0]  p;
  } poly_t;

endpackage

>>> design/scpu_reduce.sv
// Range reduction: angle times 1/pi, offset, modulo 2, shift into [-1, 1).
`timescale 1ns / 1ps

module scpu_reduce import scpu_pkg::*; (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic                      command_i,
  input  logic signed [ANGLE_W-1:0] angle_i,
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic signed [X_W-1:0]     x_o
);

  logic [1:0] v_q;
  logic [1:0] en;

  logic signed [ANGLE_W+INV_PI_W-1:0] prod;
  logic [X_W-1:0]        phase_d, phase_q;
  cmd_e                  cmd_q;
  logic [X_W-1:0]        shifted;
  logic signed [X_W-1:0] x_d, x_q;

  // a stage takes a new word when empty or when its successor moves
  assign en[1] = !v_q[1] || !out_stall_i;
  assign en[0] = !v_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
    end
  end

  // stage 0: phase = angle/pi truncated to Q1.30, modulo 2
  assign prod    = angle_i * INV_PI_Q32;
  assign phase_d = prod[PHASE_LSB+X_W-1:PHASE_LSB];

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      phase_q <= phase_d;
      cmd_q   <= cmd_e'(command_i);
    end
  end

  // stage 1: add the offset (half turn for sine, three quarters for cosine), wrap, recenter
  assign shifted = phase_q + ((cmd_q == CMD_COSINE) ? COSINE_OFFSET : SINE_OFFSET);
  assign x_d     = $signed(shifted - ONE_Q30);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      x_q <= x_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[1];
  assign x_o         = x_q;

endmodule

>>> design/scpu_horner.sv
// x squared, (x-1)(x+1) and the Horner chain, one multiply per Horner step.
`timescale 1ns / 1ps

module scpu_horner import scpu_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_stall_o,
  input  logic signed [X_W-1:0] x_i,
  output logic                  out_valid_o,
  input  logic                  out_stall_i,
  output poly_t                 poly_o
);

  localparam int NSTG = HORNER_STEPS + 1;

  logic [NSTG-1:0] v_q;
  logic [NSTG-1:0] en;

  logic signed [X_W-1:0]  x_q  [NSTG];
  logic signed [X2_W-1:0] x2_q [NSTG];
  logic signed [R1_W-1:0] r1_q [NSTG];
  logic signed [P_W-1:0]  p_q  [HORNER_STEPS];

  always_comb begin
    en[NSTG-1] = !v_q[NSTG-1] || !out_stall_i;
    for (int k = NSTG - 2; k >= 0; k--) begin
      en[k] = !v_q[k] || en[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      for (int k = 1; k < NSTG; k++) begin
        if (en[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  // stage 0: x*x and (x-1)(x+1), both rounded half up
  logic signed [R1_W-1:0]     xm1, xp1;
  logic signed [2*X_W-1:0]    sq, sq_r;
  logic signed [2*R1_W-1:0]   fac, fac_r;

  assign xm1   = R1_W'(x_i) - R1_W'(ONE_Q30);
  assign xp1   = R1_W'(x_i) + R1_W'(ONE_Q30);
  assign sq    = x_i * x_i;
  assign sq_r  = sq + (2*X_W)'(HALF_Q30);
  assign fac   = xm1 * xp1;
  assign fac_r = fac + (2*R1_W)'(HALF_Q30);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      x_q[0]  <= x_i;
      x2_q[0] <= X2_W'(sq_r >>> Q_FRAC);
      r1_q[0] <= R1_W'(fac_r >>> Q_FRAC);
    end
  end

  // stages 1..: p = round(p * x2) + c
  for (genvar k = 1; k < NSTG; k++) begin : g_step
    logic signed [P_W-1:0]      p_in;
    logic signed [P_W+X2_W-1:0] pm, pm_r;

    if (k == 1) begin : g_first
      assign p_in = COEF_Q30[0];
    end else begin : g_next
      assign p_in = p_q[k-2];
    end

    assign pm   = p_in * x2_q[k-1];
    assign pm_r = pm + (P_W+X2_W)'(HALF_Q30);

    always_ff @(posedge clk_i) begin
      if (en[k]) begin
        x_q[k]    <= x_q[k-1];
        x2_q[k]   <= x2_q[k-1];
        r1_q[k]   <= r1_q[k-1];
        p_q[k-1]  <= P_W'(pm_r >>> Q_FRAC) + COEF_Q30[k];
      end
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[NSTG-1];
  assign poly_o.x    = x_q[NSTG-1];
  assign poly_o.r1   = r1_q[NSTG-1];
  assign poly_o.p    = p_q[HORNER_STEPS-1];

endmodule

>>> design/scpu_finish.sv
// Final products (x^2-1)*p*x, output rounding, saturation and output register.
`timescale 1ns / 1ps

module scpu_finish import scpu_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  poly_t                      poly_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RESULT_W-1:0] value_o
);

  localparam logic signed [ACC_W:0] OUT_LIMIT = (ACC_W+1)'(64'sd1 <<< RESULT_FRAC_BITS);

  logic [2:0] v_q;
  logic [2:0] en;

  assign en[2] = !v_q[2] || !out_stall_i;
  assign en[1] = !v_q[1] || en[2];
  assign en[0] = !v_q[0] || en[1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (en[0]) v_q[0] <= in_valid_i;
      if (en[1]) v_q[1] <= v_q[0];
      if (en[2]) v_q[2] <= v_q[1];
    end
  end

  // stage 0: r2 = (x^2-1) * p
  logic signed [R1_W+P_W-1:0] m2, m2_r;
  logic signed [ACC_W-1:0]    r2_q;
  logic signed [X_W-1:0]      x_q;

  assign m2   = poly_i.r1 * poly_i.p;
  assign m2_r = m2 + (R1_W+P_W)'(HALF_Q30);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      r2_q <= ACC_W'(m2_r >>> Q_FRAC);
      x_q  <= poly_i.x;
    end
  end

  // stage 1: r3 = r2 * x
  logic signed [ACC_W+X_W-1:0] m3, m3_r;
  logic signed [ACC_W-1:0]     r3_q;

  assign m3   = r2_q * x_q;
  assign m3_r = m3 + (ACC_W+X_W)'(HALF_Q30);

  always_ff @(posedge clk_i) begin
    if (en[1]) begin
      r3_q <= ACC_W'(m3_r >>> Q_FRAC);
    end
  end

  // stage 2: round to the output format, clamp to +/- one
  logic signed [ACC_W:0]    rnd, scaled;
  logic signed [RESULT_W-1:0] value_d, value_q;

  assign rnd    = (ACC_W+1)'(r3_q) + (ACC_W+1)'(OUT_HALF);
  assign scaled = rnd >>> OUT_SHIFT;

  always_comb begin
    if (scaled > OUT_LIMIT) begin
      value_d = RESULT_W'(OUT_LIMIT);
    end else if (scaled < -OUT_LIMIT) begin
      value_d = RESULT_W'(-OUT_LIMIT);
    end else begin
      value_d = RESULT_W'(scaled);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[2]) begin
      value_q <= value_d;
    end
  end

  assign in_stall_o  = !en[0];
  assign out_valid_o = v_q[2];
  assign value_o     = value_q;

endmodule

>>> design/sine_cosine_polynomial_unit.sv
// Top level of the pipelined sine/cosine polynomial unit.
//
//  channel | direction | handshake                 | word
//  --------+-----------+---------------------------+---------------------------------
//  in      | to unit   | in_valid_i / in_stall_o   | command_i (0 sin, 1 cos), angle_i Q8.24
//  out     | from unit | out_valid_o / out_stall_i | value_o Q2.16, clamped to +/-1.0
//
// Throughput: one word per cycle while out_stall_i is low. Eleven register stages:
// 1/pi scale, offset and wrap, x*x with (x-1)(x+1), five Horner steps, two final
// products, round/clamp. A taken word leaves once it has passed every stage and
// out_stall_i is low. Reset clears only the stage valid bits, not the data registers.
// Each stage refills when empty, so bubbles squeeze out under out_stall_i;
// in_stall_o rises only when every stage holds a word and the output is stalled.
`timescale 1ns / 1ps

module sine_cosine_polynomial_unit import scpu_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic                       command_i,
  input  logic signed [ANGLE_W-1:0]  angle_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic signed [RESULT_W-1:0] value_o
);

  // reduce -> horner
  logic                  red_valid;
  logic                  red_stall;
  logic signed [X_W-1:0] red_x;

  // horner -> finish
  logic  hrn_valid;
  logic  hrn_stall;
  poly_t hrn_poly;

  // phase reduction into x in [-1, 1)
  scpu_reduce u_reduce (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .command_i   (command_i),
    .angle_i     (angle_i),
    .out_valid_o (red_valid),
    .out_stall_i (red_stall),
    .x_o         (red_x)
  );

  // odd polynomial core in x squared
  scpu_horner u_horner (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (red_valid),
    .in_stall_o  (red_stall),
    .x_i         (red_x),
    .out_valid_o (hrn_valid),
    .out_stall_i (hrn_stall),
    .poly_o      (hrn_poly)
  );

  // final products, rounding, saturation
  scpu_finish u_finish (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (hrn_valid),
    .in_stall_o  (hrn_stall),
    .poly_i      (hrn_poly),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .value_o     (value_o)
  );

  // result never leaves the +/- one band
  a_value_clamped : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (value_o <= $signed(RESULT_W'(1 << RESULT_FRAC_BITS)) &&
                     value_o >= -$signed(RESULT_W'(1 << RESULT_FRAC_BITS))))
    else $error("value_o outside +/- one");

  // back-pressure only comes from a full pipe behind a stalled output
  a_stall_cause : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && red_valid && hrn_valid))
    else $error("input stalled without a full, blocked pipeline");

  // (x-1)(x+1) is never positive for x in [-1, 1)
  a_factor_sign : assert property (@(posedge clk_i) disable iff (!rst_ni)
    hrn_valid |-> (hrn_poly.r1 <= 0))
    else $error("(x-1)(x+1) positive");

endmodule
